### rtl/apdc_pkg.sv
// ----------------------------------------------------------------------------
// apdc_pkg
// Shared types, constants and the CRC-8 byte update for the addressed packet
// deframer.
// ----------------------------------------------------------------------------
package apdc_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_VALUE  = 1'b1;

    localparam int ADDR_W  = 7;
    localparam int VALUE_W = 20;
    localparam int CMD_W   = 12;

    localparam logic [7:0] ADDR_MARK  = 8'h80;
    localparam logic [7:0] CHAR_MASK  = 8'h7F;
    localparam logic [7:0] FIELD_MASK = 8'h3F;
    localparam logic [7:0] CRC_POLY   = 8'h18;
    localparam logic [7:0] CRC_TOP    = 8'h80;

    // Packet lengths in bytes, address byte included
    localparam logic [2:0] LEN_WRITE = 3'd6;
    localparam logic [2:0] LEN_READ  = 3'd4;

    // Positions of interest inside a packet
    localparam logic [2:0] POS_IDLE   = 3'd0;
    localparam logic [2:0] POS_CMD    = 3'd1;
    localparam logic [2:0] POS_RD_CRC = 3'd2;
    localparam logic [2:0] POS_WR_CRC = 3'd4;

    // Reply beat numbers within a read answer
    localparam logic [2:0] BEAT_REQ  = 3'd0;
    localparam logic [2:0] BEAT_R0   = 3'd1;
    localparam logic [2:0] BEAT_R1   = 3'd2;
    localparam logic [2:0] BEAT_R2   = 3'd3;
    localparam logic [2:0] BEAT_R3   = 3'd4;

    typedef enum logic [1:0] {
        EV_CRC_ERROR  = 2'd0,
        EV_READ_REQ   = 2'd1,
        EV_WRITE_REQ  = 2'd2,
        EV_REPLY_BYTE = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [CMD_W-1:0]     cmd;
        logic [VALUE_W-1:0]   data;
        logic [VALUE_W-1:0]   reply;
    } apdc_event_t;

    // One byte of the reflected CRC-8, least significant bit first
    function automatic logic [7:0] crc8_byte(input logic [7:0] data,
                                             input logic [7:0] crc_in);
        logic [7:0] crc;
        crc = crc_in;
        for (int b = 0; b < 8; b++)
        begin
            if ((crc[0] ^ data[b]) == 1'b1)
            begin
                crc = ((crc ^ CRC_POLY) >> 1) | CRC_TOP;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/addressed_packet_deframer_crc8.sv
// ----------------------------------------------------------------------------
// addressed_packet_deframer_crc8
// Top level: takes received serial bytes, frames addressed read and write
// packets, checks their CRC-8 and issues requests, replies and errors.
// ----------------------------------------------------------------------------
// The block accepts one received byte per beat and handles each one on
// arrival: the packet position, the stored packet bytes and a running
// CRC-8 (1-Wire form) advance as the byte is taken. A packet opens with the
// byte node_address | 0x80; bit 6 of the following byte selects a 6-byte
// write or a 4-byte read. The final byte carries CRC bits 6..0, bit 7 rides
// in bit 6 of the byte before it. When the final byte arrives the check is
// resolved and one event is placed in a pending slot: a write request, a
// read request or a CRC error. A sequencer then issues the event as result
// beats: one beat for a write or an error, five for a read (the request and
// four framed reply bytes built from reply_value). The event moves from the
// pending slot into the sequencer at the next edge when the sequencer is
// free; its first result beat is then offered from the sequencer register.
// Bytes are accepted every cycle while the pending slot is empty; input
// stalls, for every byte, while the slot is occupied, which is at most
// until the sequencer drains its current event. Configuration writes take
// effect at the next edge; write only between packets or while no results
// are owed.
// ----------------------------------------------------------------------------
module addressed_packet_deframer_crc8 (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write_en,
    input  logic [apdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apdc_pkg::VALUE_W-1:0]    cfg_data,
    // received bytes
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    // results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      event_kind,
    output logic [11:0]                     command_code,
    output logic [19:0]                     write_data,
    output logic [7:0]                      reply_byte,
    output logic                            last
);
    import apdc_pkg::*;

    logic [ADDR_W-1:0]  node_address_reg;
    logic [VALUE_W-1:0] reply_value_reg;

    logic [2:0] pos_reg, pos_next;
    logic [2:0] exp_reg, exp_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] pkt_reg [1:4];

    logic        in_acc;
    logic        p_full;
    logic        addr_hit;
    logic [2:0]  exp_eff;
    logic [2:0]  pos_inc;
    logic        is_write;
    logic        carrier;
    logic        done;
    logic [7:0]  body_byte;
    logic [7:0]  want;
    logic        ev_valid;
    apdc_event_t ev;

    assign in_stall = p_full;
    assign in_acc   = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 7'd7;
            reply_value_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_NODE_ADDRESS: node_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_REPLY_VALUE:  reply_value_reg  <= cfg_data;
                default:          node_address_reg <= node_address_reg;
            endcase
        end
    end

    // Packet framing and running CRC
    assign addr_hit = (rx_byte == (ADDR_MARK | {1'b0, node_address_reg}));
    assign exp_eff  = (pos_reg == POS_CMD) ? (rx_byte[6] ? LEN_WRITE : LEN_READ) : exp_reg;
    assign is_write = (exp_eff == LEN_WRITE);
    assign pos_inc  = pos_reg + 3'd1;
    assign done     = (pos_reg != POS_IDLE) && (pos_inc >= exp_eff);
    // clear the top two bits of the byte that carries CRC bit 7
    assign carrier  = (is_write && pos_reg == POS_WR_CRC) ||
                      (!is_write && pos_reg == POS_RD_CRC);
    assign body_byte = carrier ? (rx_byte & FIELD_MASK) : rx_byte;
    assign want = {(is_write ? pkt_reg[4][6] : pkt_reg[2][6]), rx_byte[6:0]};

    always_comb
    begin
        pos_next = pos_reg;
        exp_next = exp_reg;
        crc_next = crc_reg;
        if (in_acc)
        begin
            if (pos_reg == POS_IDLE)
            begin
                if (addr_hit)
                begin
                    pos_next = POS_CMD;
                    crc_next = crc8_byte(rx_byte, 8'h00);
                end
            end
            else
            begin
                exp_next = exp_eff;
                crc_next = crc8_byte(body_byte, crc_reg);
                pos_next = done ? POS_IDLE : pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_IDLE;
            exp_reg <= 3'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        for (int i = 1; i <= 4; i++)
        begin
            if (in_acc && pos_reg == i[2:0])
            begin
                pkt_reg[i] <= rx_byte;
            end
        end
    end

    // Event built from the closing byte
    assign ev_valid = in_acc && done;

    always_comb
    begin
        ev.reply = reply_value_reg;
        ev.cmd   = '0;
        ev.data  = '0;
        if (crc_reg != want)
        begin
            ev.kind = EV_CRC_ERROR;
        end
        else if (is_write)
        begin
            ev.kind = EV_WRITE_REQ;
            ev.cmd  = {6'd0, pkt_reg[1][5:0]};
            ev.data = {pkt_reg[4][5:0], pkt_reg[3][6:0], pkt_reg[2][6:0]};
        end
        else
        begin
            ev.kind = EV_READ_REQ;
            ev.cmd  = {pkt_reg[2][5:0], pkt_reg[1][5:0]};
        end
    end

    apdc_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_valid     (ev_valid),
        .ev           (ev),
        .p_full       (p_full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .command_code (command_code),
        .write_data   (write_data),
        .reply_byte   (reply_byte),
        .last         (last)
    );

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < LEN_WRITE)
        else $error("packet position beyond longest packet");

    a_idle_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |=> pos_reg == POS_IDLE)
        else $error("position not cleared after packet close");

    a_open_on_address: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && pos_reg == POS_IDLE && !addr_hit) |=> pos_reg == POS_IDLE)
        else $error("packet opened without address byte");

endmodule

### rtl/apdc_emit.sv
// ----------------------------------------------------------------------------
// apdc_emit
// Event slot and output sequencer: holds one pending event and streams the
// result beats, including the framed four-byte reply of a read.
// ----------------------------------------------------------------------------
module apdc_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ev_valid,
    input  apdc_pkg::apdc_event_t ev,
    output logic                 p_full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_kind,
    output logic [11:0]          command_code,
    output logic [19:0]          write_data,
    output logic [7:0]           reply_byte,
    output logic                 last
);
    import apdc_pkg::*;

    logic        p_valid_reg, p_valid_next;
    apdc_event_t p_ev_reg;
    logic        s_valid_reg, s_valid_next;
    apdc_event_t s_ev_reg;
    logic [2:0]  s_beat_reg, s_beat_next;
    logic [7:0]  s_crc_reg, s_crc_next;

    logic       s_last;
    logic       s_free;
    logic       s_load;
    logic       beat_done;
    logic [7:0] r0, r1, r2, p_r0;

    assign r0   = {1'b0, s_ev_reg.reply[6:0]};
    assign r1   = {1'b0, s_ev_reg.reply[13:7]};
    assign r2   = {2'b00, s_ev_reg.reply[19:14]};
    assign p_r0 = {1'b0, p_ev_reg.reply[6:0]};

    assign s_last    = (s_ev_reg.kind != EV_READ_REQ) || (s_beat_reg == BEAT_R3);
    assign beat_done = s_valid_reg && !out_stall;
    assign s_free    = !s_valid_reg || (beat_done && s_last);
    assign s_load    = p_valid_reg && s_free;
    assign p_full    = p_valid_reg;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (s_load)
        begin
            p_valid_next = 1'b0;
        end
        if (ev_valid)
        begin
            p_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        s_valid_next = s_valid_reg;
        s_beat_next  = s_beat_reg;
        s_crc_next   = s_crc_reg;
        if (s_load)
        begin
            s_valid_next = 1'b1;
            s_beat_next  = BEAT_REQ;
            s_crc_next   = crc8_byte(p_r0, 8'h00);
        end
        else if (beat_done)
        begin
            if (s_last)
            begin
                s_valid_next = 1'b0;
            end
            else
            begin
                s_beat_next = s_beat_reg + 3'd1;
                // fold reply bytes r1 and r2 into the CRC ahead of their own beats
                case (s_beat_reg)
                    BEAT_REQ: s_crc_next = crc8_byte(r1, s_crc_reg);
                    BEAT_R0:  s_crc_next = crc8_byte(r2, s_crc_reg);
                    default:  s_crc_next = s_crc_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            s_beat_reg  <= BEAT_REQ;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            s_valid_reg <= s_valid_next;
            s_beat_reg  <= s_beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_crc_reg <= s_crc_next;
        if (ev_valid)
        begin
            p_ev_reg <= ev;
        end
        if (s_load)
        begin
            s_ev_reg <= p_ev_reg;
        end
    end

    // Output beat
    assign out_valid = s_valid_reg;
    assign last      = s_last;

    always_comb
    begin
        if (s_beat_reg == BEAT_REQ)
        begin
            event_kind   = s_ev_reg.kind;
            command_code = s_ev_reg.cmd;
            write_data   = s_ev_reg.data;
        end
        else
        begin
            event_kind   = EV_REPLY_BYTE;
            command_code = '0;
            write_data   = '0;
        end
        case (s_beat_reg)
            BEAT_R0: reply_byte = r0;
            BEAT_R1: reply_byte = r1;
            BEAT_R2: reply_byte = {1'b0, s_crc_reg[7], r2[5:0]};
            BEAT_R3: reply_byte = {1'b0, s_crc_reg[6:0]};
            default: reply_byte = 8'h00;
        endcase
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> !p_valid_reg)
        else $error("event arrived while pending slot full");

    a_beats_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid_reg && s_beat_reg != BEAT_REQ) |-> s_ev_reg.kind == EV_READ_REQ)
        else $error("reply beat outside a read answer");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> (s_beat_reg <= BEAT_R3))
        else $error("beat counter out of range");

    a_reply_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> (out_valid && event_kind == EV_REPLY_BYTE))
        else $error("reply beat missing after non-final beat");

endmodule
